[src/rre_pkg.sv]
// Shared types, constants and register codes for the retransmit timeout engine.
package rre_pkg;

    localparam int FRACTION_BITS_DEF = 3;
    localparam int SEQ_W             = 32;
    localparam int MS_W              = 16;
    localparam int RETRY_W           = 4;
    localparam int IN_TDATA_W        = 48;
    localparam int OUT_TDATA_W       = 56;
    localparam int APB_ADDR_W        = 5;
    localparam int APB_DATA_W        = 32;

    localparam logic [SEQ_W-1:0]   SIGNATURE      = 32'hF000_0000;
    localparam logic [SEQ_W-1:0]   FIRST_SEQ      = 32'd240;
    localparam logic [MS_W-1:0]    HALF_SECOND_MS = 16'd500;
    localparam logic [RETRY_W-1:0] RETRY_MAX      = 4'd15;

    localparam logic [MS_W-1:0]    RST_MIN_RTO    = 16'd1000;
    localparam logic [MS_W-1:0]    RST_MAX_RTO    = 16'd8000;
    localparam logic [2:0]         RST_SRTT_SHIFT = 3'd3;
    localparam logic [2:0]         RST_VAR_SHIFT  = 3'd2;
    localparam logic [RETRY_W-1:0] RST_BACKOFF    = 4'd3;
    localparam logic [RETRY_W-1:0] RST_GIVE_UP    = 4'd6;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_TIMEOUT = 2'd1,
        OP_REPLY   = 2'd2,
        OP_RESTART = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_TRANSMIT  = 3'd0,
        ST_GAVE_UP   = 3'd1,
        ST_ACCEPTED  = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_INACTIVE  = 3'd4,
        ST_RESTARTED = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        REG_MIN_RTO    = 3'd0,
        REG_MAX_RTO    = 3'd1,
        REG_SRTT_SHIFT = 3'd2,
        REG_VAR_SHIFT  = 3'd3,
        REG_BACKOFF    = 3'd4,
        REG_GIVE_UP    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [MS_W-1:0]    min_rto;
        logic [MS_W-1:0]    max_rto;
        logic [2:0]         srtt_shift;
        logic [2:0]         var_shift;
        logic [RETRY_W-1:0] backoff_after;
        logic [RETRY_W-1:0] give_up;
    } t_cfg;

    typedef struct packed {
        t_opcode            op;
        logic [SEQ_W-1:0]   seq;
        logic [MS_W-1:0]    rtt_ms;
    } t_event;

    typedef struct packed {
        t_status            status;
        logic [SEQ_W-1:0]   seq;
        logic [MS_W-1:0]    rto_ms;
        logic [RETRY_W-1:0] retry;
    } t_result;

    // Stream tdata layouts, MSB first.
    typedef struct packed {
        logic [MS_W-1:0]    rtt_ms;
        logic [SEQ_W-1:0]   seq;
    } t_in_data;

    typedef struct packed {
        logic [3:0]         pad;
        logic [RETRY_W-1:0] retry;
        logic [MS_W-1:0]    rto_ms;
        logic [SEQ_W-1:0]   seq;
    } t_out_data;

endpackage

[src/rudp_retransmit_rto_engine.sv]
// Top level: event stream in, stamped result stream out, APB configuration.
//
// Events enter on the s_ stream: s_tuser carries the opcode (send new,
// timeout, reply, restart), s_tdata the reply sequence word and measured RTT.
// Every accepted event gives exactly one result beat on the m_ stream:
// m_tuser carries the status, m_tdata the sequence word to stamp, the
// current RTO in whole ms and the retry count.
// An event is held in an input register; once the output register is free
// it updates the engine state and its result is captured in the output
// register.
// Throughput is one event per cycle while m_tready is high: the estimator update
// and RTO clamp are a single shift-add-compare pass between the two registers.
// When m_tready is low the result holds and one more event waits in the
// input register; s_tready drops only while both registers are full.
// Reset clears both stream registers, loads the default limits and gains
// into the APB registers and puts the engine in its restart state
// (active, sequence 240, RTO at the minimum, variance at 500 ms).
// Write configuration only while no event is in flight.
module rudp_retransmit_rto_engine
    import rre_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // reply_sequence[31:0], measured_rtt_ms[47:32]
    input  logic [1:0]             s_tuser,   // opcode[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // sequence_word[31:0], rto_ms[47:32],
                                              // retry_count[51:48], zero[55:52]
    output logic [2:0]             m_tuser,   // status[2:0]
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    t_cfg      cfg;
    t_in_data  in_data;
    t_out_data out_data;
    t_result   eng_res;
    logic      out_adv;
    logic      fire;

    logic      r_in_valid;
    t_event    r_ev;
    logic      r_out_valid;
    t_result   r_res;

    rre_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rre_engine #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_ev    (r_ev),
        .i_cfg   (cfg),
        .o_res   (eng_res)
    );

    assign out_adv  = !r_out_valid || m_tready;
    assign fire     = r_in_valid && out_adv;
    assign s_tready = !r_in_valid || out_adv;
    assign in_data  = s_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_ev.op     <= t_opcode'(s_tuser);
            r_ev.seq    <= in_data.seq;
            r_ev.rtt_ms <= in_data.rtt_ms;
        end
    end

    // Advance the result register whenever the receiver is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= eng_res;
        end
    end

    assign out_data.pad    = '0;
    assign out_data.retry  = r_res.retry;
    assign out_data.rto_ms = r_res.rto_ms;
    assign out_data.seq    = r_res.seq;

    assign m_tvalid = r_out_valid;
    assign m_tdata  = out_data;
    assign m_tuser  = r_res.status;

endmodule

[src/rre_apb_regs.sv]
// APB register file holding the timeout limits, gains and retry thresholds.
module rre_apb_regs
    import rre_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_MIN_RTO:    n_cfg.min_rto       = pwdata[MS_W-1:0];
                REG_MAX_RTO:    n_cfg.max_rto       = pwdata[MS_W-1:0];
                REG_SRTT_SHIFT: n_cfg.srtt_shift    = pwdata[2:0];
                REG_VAR_SHIFT:  n_cfg.var_shift     = pwdata[2:0];
                REG_BACKOFF:    n_cfg.backoff_after = pwdata[RETRY_W-1:0];
                REG_GIVE_UP:    n_cfg.give_up       = pwdata[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_RTO:    prdata = APB_DATA_W'(r_cfg.min_rto);
            REG_MAX_RTO:    prdata = APB_DATA_W'(r_cfg.max_rto);
            REG_SRTT_SHIFT: prdata = APB_DATA_W'(r_cfg.srtt_shift);
            REG_VAR_SHIFT:  prdata = APB_DATA_W'(r_cfg.var_shift);
            REG_BACKOFF:    prdata = APB_DATA_W'(r_cfg.backoff_after);
            REG_GIVE_UP:    prdata = APB_DATA_W'(r_cfg.give_up);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_rto       <= RST_MIN_RTO;
            r_cfg.max_rto       <= RST_MAX_RTO;
            r_cfg.srtt_shift    <= RST_SRTT_SHIFT;
            r_cfg.var_shift     <= RST_VAR_SHIFT;
            r_cfg.backoff_after <= RST_BACKOFF;
            r_cfg.give_up       <= RST_GIVE_UP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[src/rre_estimator.sv]
// Jacobson RTT estimator update and RTO clamping, shift-and-add only.
module rre_estimator
    import rre_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  t_cfg                        i_cfg,
    input  logic [MS_W+FRACTION_BITS-1:0] i_srtt,
    input  logic [MS_W+FRACTION_BITS-1:0] i_var,
    input  logic [MS_W+FRACTION_BITS-1:0] i_rto,
    input  logic [MS_W-1:0]             i_rtt_ms,
    output logic [MS_W+FRACTION_BITS-1:0] o_srtt,
    output logic [MS_W+FRACTION_BITS-1:0] o_var,
    output logic [MS_W+FRACTION_BITS-1:0] o_rto_est,
    output logic [MS_W+FRACTION_BITS-1:0] o_rto_dbl
);

    localparam int W  = MS_W + FRACTION_BITS;
    localparam int SW = W + 3;

    logic [W-1:0]  rtt_fx;
    logic          neg;
    logic [W-1:0]  mag;
    logic [W-1:0]  step;
    logic [W-1:0]  var_up;
    logic [W-1:0]  var_dn;
    logic [SW-1:0] sum;
    logic [SW-1:0] dbl;
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    logic [SW-1:0] est_c;
    logic [SW-1:0] dbl_c;

    // Below min wins over above max.
    function automatic logic [SW-1:0] clamp_fx(input logic [SW-1:0] v,
                                                input logic [SW-1:0] l,
                                                input logic [SW-1:0] h);
        logic [SW-1:0] r;
        if (v < l) begin
            r = l;
        end else if (v > h) begin
            r = h;
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign rtt_fx = W'(i_rtt_ms) << FRACTION_BITS;
    assign neg    = rtt_fx < i_srtt;
    assign mag    = neg ? (i_srtt - rtt_fx) : (rtt_fx - i_srtt);
    assign step   = mag >> i_cfg.srtt_shift;
    assign o_srtt = neg ? (i_srtt - step) : (i_srtt + step);

    // Decay toward the deviation magnitude; shift the magnitude, not the signed value.
    assign var_up = i_var + ((mag - i_var) >> i_cfg.var_shift);
    assign var_dn = i_var - ((i_var - mag) >> i_cfg.var_shift);
    assign o_var  = (mag >= i_var) ? var_up : var_dn;

    assign lo  = SW'(i_cfg.min_rto) << FRACTION_BITS;
    assign hi  = SW'(i_cfg.max_rto) << FRACTION_BITS;
    assign sum = SW'(o_srtt) + (SW'(o_var) << 2);
    assign dbl = SW'(i_rto) << 1;

    assign est_c     = clamp_fx(sum, lo, hi);
    assign dbl_c     = clamp_fx(dbl, lo, hi);
    assign o_rto_est = est_c[W-1:0];
    assign o_rto_dbl = dbl_c[W-1:0];

endmodule

[src/rre_engine.sv]
// Retransmit state: sequence numbering, retry accounting, backoff and estimator state.
module rre_engine
    import rre_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_event  i_ev,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int W = MS_W + FRACTION_BITS;

    logic               r_active,  n_active;
    logic               r_peer,    n_peer;
    logic               r_backoff, n_backoff;
    logic               r_await,   n_await;
    logic [SEQ_W-1:0]   r_next,    n_next;
    logic [SEQ_W-1:0]   r_pending, n_pending;
    logic [RETRY_W-1:0] r_retries, n_retries;
    logic [W-1:0]       r_srtt,    n_srtt;
    logic [W-1:0]       r_var,     n_var;
    logic [W-1:0]       r_rto,     n_rto;

    logic [W-1:0]       est_srtt;
    logic [W-1:0]       est_var;
    logic [W-1:0]       est_rto;
    logic [W-1:0]       dbl_rto;
    logic [RETRY_W-1:0] ret_chk;
    logic               chk_bo;
    logic               chk_give;
    t_status            status;

    rre_estimator #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_est (
        .i_cfg     (i_cfg),
        .i_srtt    (r_srtt),
        .i_var     (r_var),
        .i_rto     (r_rto),
        .i_rtt_ms  (i_ev.rtt_ms),
        .o_srtt    (est_srtt),
        .o_var     (est_var),
        .o_rto_est (est_rto),
        .o_rto_dbl (dbl_rto)
    );

    // Timeouts count the retry first, saturating, then run the checks.
    assign ret_chk  = (i_ev.op == OP_TIMEOUT && r_retries != RETRY_MAX) ?
                      r_retries + 1'b1 : r_retries;
    assign chk_bo   = ret_chk >= i_cfg.backoff_after;
    assign chk_give = (chk_bo && !r_peer) || (ret_chk >= i_cfg.give_up);

    always_comb begin
        n_active  = r_active;
        n_peer    = r_peer;
        n_backoff = r_backoff;
        n_await   = r_await;
        n_next    = r_next;
        n_pending = r_pending;
        n_retries = r_retries;
        n_srtt    = r_srtt;
        n_var     = r_var;
        n_rto     = r_rto;
        status    = ST_INACTIVE;
        if (i_ev.op == OP_RESTART) begin
            n_active  = 1'b1;
            n_peer    = 1'b0;
            n_backoff = 1'b0;
            n_await   = 1'b0;
            n_next    = FIRST_SEQ;
            n_pending = '0;
            n_retries = '0;
            n_srtt    = '0;
            n_var     = W'(HALF_SECOND_MS) << FRACTION_BITS;
            n_rto     = W'(i_cfg.min_rto) << FRACTION_BITS;
            status    = ST_RESTARTED;
        end else if (r_active) begin
            case (i_ev.op)
                OP_SEND, OP_TIMEOUT: begin
                    if (i_ev.op == OP_SEND || r_await) begin
                        if (i_ev.op == OP_SEND) begin
                            n_pending = r_next | SIGNATURE;
                            n_next    = r_next + 1'b1;
                        end else if (r_backoff) begin
                            n_rto = dbl_rto;
                        end
                        n_retries = ret_chk;
                        n_await   = 1'b1;
                        if (chk_bo && r_peer) begin
                            n_backoff = 1'b1;
                        end
                        if (chk_give) begin
                            n_active = 1'b0;
                            n_await  = 1'b0;
                            status   = ST_GAVE_UP;
                        end else begin
                            status = ST_TRANSMIT;
                        end
                    end
                end
                OP_REPLY: begin
                    if (r_await && i_ev.seq == r_pending) begin
                        n_srtt    = est_srtt;
                        n_var     = est_var;
                        n_rto     = est_rto;
                        n_peer    = 1'b1;
                        n_retries = '0;
                        n_await   = 1'b0;
                        status    = ST_ACCEPTED;
                    end else begin
                        status = ST_IGNORED;
                    end
                end
                default: status = ST_INACTIVE;
            endcase
        end
    end

    assign o_res.status = status;
    assign o_res.seq    = n_pending;
    assign o_res.rto_ms = n_rto[W-1:FRACTION_BITS];
    assign o_res.retry  = n_retries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b1;
            r_peer    <= 1'b0;
            r_backoff <= 1'b0;
            r_await   <= 1'b0;
            r_next    <= FIRST_SEQ;
            r_pending <= '0;
            r_retries <= '0;
            r_srtt    <= '0;
            r_var     <= W'(HALF_SECOND_MS) << FRACTION_BITS;
            r_rto     <= W'(RST_MIN_RTO) << FRACTION_BITS;
        end else if (i_fire) begin
            r_active  <= n_active;
            r_peer    <= n_peer;
            r_backoff <= n_backoff;
            r_await   <= n_await;
            r_next    <= n_next;
            r_pending <= n_pending;
            r_retries <= n_retries;
            r_srtt    <= n_srtt;
            r_var     <= n_var;
            r_rto     <= n_rto;
        end
    end

endmodule

[src/rre_checker.sv]
// Port-level checker for the retransmit engine and its bind to the top level.
module rre_checker
    import rre_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [2:0]             m_tuser
);

    t_out_data od;

    assign od = m_tdata;

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_sig_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == ST_TRANSMIT |-> od.seq[31:28] == SIGNATURE[31:28])
        else $error("transmitted sequence lacks signature bits");

    a_retry_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == ST_ACCEPTED || m_tuser == ST_RESTARTED)
        |-> od.retry == '0)
        else $error("retry count not cleared by reply or restart");

    a_restart_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == ST_RESTARTED |-> od.seq == '0 && od.pad == '0)
        else $error("restart left a pending sequence word");

endmodule

bind rudp_retransmit_rto_engine rre_checker u_rre_checker (.*);
